/* rtl/bz_pkg.sv */
// Shared constants for the cubic Bezier point and tangent evaluator.
// No dependencies; used by every other file of the block.
package bz_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int T_FRAC_BITS = 16;

  // Pipeline stages from request to result.
  localparam int PIPE_DEPTH = 7;

  localparam int REG_IDX_WIDTH = 3;

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_CTRL1_X = 3'd2,
    REG_CTRL1_Y = 3'd3,
    REG_CTRL2_X = 3'd4,
    REG_CTRL2_Y = 3'd5,
    REG_END_X   = 3'd6,
    REG_END_Y   = 3'd7
  } reg_idx_t;

endpackage

/* rtl/bz_weights.sv */
// Bernstein weight pipeline: saturates t and builds the basis weights in four stages.
// Depends on bz_pkg.
module bz_weights #(
  parameter int T_FRAC_BITS = bz_pkg::T_FRAC_BITS
) (
  input  logic                 clk,
  input  logic [T_FRAC_BITS:0] param_t,
  output logic [T_FRAC_BITS:0] w0,
  output logic [T_FRAC_BITS:0] w1,
  output logic [T_FRAC_BITS:0] w2,
  output logic [T_FRAC_BITS:0] w3,
  output logic [T_FRAC_BITS:0] uu,
  output logic [T_FRAC_BITS:0] ut,
  output logic [T_FRAC_BITS:0] tt
);

  localparam int TW = T_FRAC_BITS + 1;
  localparam int MW = 2 * TW;
  localparam logic [TW-1:0]   ONE   = TW'(1) << T_FRAC_BITS;
  localparam logic [MW-1:0]   HALF  = MW'(1) << (T_FRAC_BITS - 1);
  localparam logic [MW+1:0]   HALF3 = (MW + 2)'(1) << (T_FRAC_BITS - 1);

  logic [TW-1:0] tc0, u0;
  logic [TW-1:0] tc1, u1, tc2, u2;
  logic [MW-1:0] m_uu1, m_tt1, m_ut1;
  logic [TW-1:0] uu2, tt2, ut2, uu3, tt3, ut3;
  logic [MW-1:0] p_w1, p_w2;
  logic [MW-1:0] m_w0, m_w3;
  logic [MW+1:0] m_w1, m_w2;

  // t above one clamps to one
  assign tc0 = (param_t > ONE) ? ONE : param_t;
  assign u0  = ONE - tc0;

  assign p_w1 = uu2 * tc2;
  assign p_w2 = u2 * tt2;

  always_ff @(posedge clk) begin
    // stage 1: squares and cross term
    tc1   <= tc0;
    u1    <= u0;
    m_uu1 <= u0 * u0;
    m_tt1 <= tc0 * tc0;
    m_ut1 <= u0 * tc0;
    // stage 2: round to Q1.T
    tc2 <= tc1;
    u2  <= u1;
    uu2 <= TW'((m_uu1 + HALF) >> T_FRAC_BITS);
    tt2 <= TW'((m_tt1 + HALF) >> T_FRAC_BITS);
    ut2 <= TW'((m_ut1 + HALF) >> T_FRAC_BITS);
    // stage 3: cubic products, x3 by shift-add
    m_w0 <= uu2 * u2;
    m_w1 <= {1'b0, p_w1, 1'b0} + {2'b00, p_w1};
    m_w2 <= {1'b0, p_w2, 1'b0} + {2'b00, p_w2};
    m_w3 <= tt2 * tc2;
    uu3  <= uu2;
    tt3  <= tt2;
    ut3  <= ut2;
    // stage 4: round weights
    w0 <= TW'((m_w0 + HALF) >> T_FRAC_BITS);
    w1 <= TW'((m_w1 + HALF3) >> T_FRAC_BITS);
    w2 <= TW'((m_w2 + HALF3) >> T_FRAC_BITS);
    w3 <= TW'((m_w3 + HALF) >> T_FRAC_BITS);
    uu <= uu3;
    ut <= ut3;
    tt <= tt3;
  end

endmodule

/* rtl/bz_axis.sv */
// One coordinate axis: weighted point sum and derivative, three stages.
// Depends on bz_pkg; fed by bz_weights.
module bz_axis #(
  parameter int COORD_WIDTH = bz_pkg::COORD_WIDTH,
  parameter int T_FRAC_BITS = bz_pkg::T_FRAC_BITS
) (
  input  logic                          clk,
  input  logic signed [COORD_WIDTH-1:0] p0,
  input  logic signed [COORD_WIDTH-1:0] p1,
  input  logic signed [COORD_WIDTH-1:0] p2,
  input  logic signed [COORD_WIDTH-1:0] p3,
  input  logic        [T_FRAC_BITS:0]   w0,
  input  logic        [T_FRAC_BITS:0]   w1,
  input  logic        [T_FRAC_BITS:0]   w2,
  input  logic        [T_FRAC_BITS:0]   w3,
  input  logic        [T_FRAC_BITS:0]   uu,
  input  logic        [T_FRAC_BITS:0]   ut,
  input  logic        [T_FRAC_BITS:0]   tt,
  output logic signed [COORD_WIDTH-1:0] point,
  output logic signed [COORD_WIDTH+2:0] slope
);

  localparam int C   = COORD_WIDTH;
  localparam int TW  = T_FRAC_BITS + 1;
  localparam int PW  = C + TW + 1;
  localparam int PSW = PW + 3;
  localparam int SPW = C + TW + 2;
  localparam int DW  = SPW + 2;
  localparam int D3W = DW + 2;

  localparam logic signed [PSW-1:0] HALF_P = PSW'(1) <<< (T_FRAC_BITS - 1);
  localparam logic signed [D3W-1:0] HALF_D = D3W'(1) <<< (T_FRAC_BITS - 1);
  localparam logic signed [PSW-1:0] PMAX   = (PSW'(1) <<< (C - 1)) - PSW'(1);
  localparam logic signed [PSW-1:0] PMIN   = ~PMAX;
  localparam logic signed [D3W-1:0] SMAX   = (D3W'(3) <<< C) - D3W'(1);
  localparam logic signed [D3W-1:0] SMIN   = ~SMAX;

  logic signed [C:0]     d10, d21, d32;
  logic signed [PW-1:0]  pp0, pp1, pp2, pp3;
  logic signed [SPW-1:0] sa, sb, sc;
  logic signed [PSW-1:0] psum, pr, pclamp;
  logic signed [DW-1:0]  dsum;
  logic signed [D3W-1:0] d3, sr, sclamp;

  // control point differences (static between requests)
  assign d10 = $signed({p1[C-1], p1}) - $signed({p0[C-1], p0});
  assign d21 = $signed({p2[C-1], p2}) - $signed({p1[C-1], p1});
  assign d32 = $signed({p3[C-1], p3}) - $signed({p2[C-1], p2});

  // final stage: x3, round, saturate
  assign pr     = psum >>> T_FRAC_BITS;
  assign d3     = (D3W'(dsum) <<< 1) + D3W'(dsum) + HALF_D;
  assign sr     = d3 >>> T_FRAC_BITS;
  assign pclamp = (pr > PMAX) ? PMAX : ((pr < PMIN) ? PMIN : pr);
  assign sclamp = (sr > SMAX) ? SMAX : ((sr < SMIN) ? SMIN : sr);

  always_ff @(posedge clk) begin
    // stage 5: products
    pp0 <= p0 * $signed({1'b0, w0});
    pp1 <= p1 * $signed({1'b0, w1});
    pp2 <= p2 * $signed({1'b0, w2});
    pp3 <= p3 * $signed({1'b0, w3});
    sa  <= d10 * $signed({1'b0, uu});
    sb  <= d21 * $signed({1'b0, ut});
    sc  <= d32 * $signed({1'b0, tt});
    // stage 6: sums, rounding half folded into point sum
    psum <= PSW'(pp0) + PSW'(pp1) + PSW'(pp2) + PSW'(pp3) + HALF_P;
    dsum <= DW'(sa) + (DW'(sb) <<< 1) + DW'(sc);
    // stage 7
    point <= pclamp[C-1:0];
    slope <= sclamp[C+2:0];
  end

endmodule

/* rtl/cubic_bezier_point_and_tangent.sv */
// Cubic Bezier point and tangent evaluator, top level.
// Each accepted request gives one done strobe at the end of the valid pipeline.
// Throughput: one request per cycle; busy is high only while rst is high, the
// seven-stage pipeline advances every cycle and the receiver cannot stall.
// Reset (synchronous, rst high) clears the valid pipeline and the control points to zero.
// Depends on bz_pkg, bz_weights, bz_axis.
module cubic_bezier_point_and_tangent #(
  parameter int COORD_WIDTH = bz_pkg::COORD_WIDTH,
  parameter int T_FRAC_BITS = bz_pkg::T_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [T_FRAC_BITS:0]          param_t,
  // result channel
  output logic                                 done,
  output logic signed [COORD_WIDTH-1:0]        point_x,
  output logic signed [COORD_WIDTH-1:0]        point_y,
  output logic signed [COORD_WIDTH+2:0]        slope_x,
  output logic signed [COORD_WIDTH+2:0]        slope_y,
  // control point write port
  input  logic                                 wr_en,
  input  logic        [bz_pkg::REG_IDX_WIDTH-1:0] wr_index,
  input  logic        [COORD_WIDTH-1:0]        wr_data
);

  localparam int D = bz_pkg::PIPE_DEPTH;

  logic signed [COORD_WIDTH-1:0] start_x, start_y, ctrl1_x, ctrl1_y;
  logic signed [COORD_WIDTH-1:0] ctrl2_x, ctrl2_y, end_x, end_y;
  logic [T_FRAC_BITS:0] w0, w1, w2, w3, uu, ut, tt;
  logic [D-1:0] vld;
  logic         accept;

  // Pipeline never backs up; requests are refused only during reset,
  // when the valid pipeline is being cleared.
  assign busy   = rst;
  assign accept = start && !busy;

  // Control point registers. The index space is exactly eight wide.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      ctrl1_x <= '0;
      ctrl1_y <= '0;
      ctrl2_x <= '0;
      ctrl2_y <= '0;
      end_x   <= '0;
      end_y   <= '0;
    end else if (wr_en) begin
      unique case (bz_pkg::reg_idx_t'(wr_index))
        bz_pkg::REG_START_X: start_x <= wr_data;
        bz_pkg::REG_START_Y: start_y <= wr_data;
        bz_pkg::REG_CTRL1_X: ctrl1_x <= wr_data;
        bz_pkg::REG_CTRL1_Y: ctrl1_y <= wr_data;
        bz_pkg::REG_CTRL2_X: ctrl2_x <= wr_data;
        bz_pkg::REG_CTRL2_Y: ctrl2_y <= wr_data;
        bz_pkg::REG_END_X:   end_x   <= wr_data;
        bz_pkg::REG_END_Y:   end_y   <= wr_data;
        default: ;
      endcase
    end
  end

  // Valid bit rides alongside the data; payload stages carry no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[D-2:0], accept};
    end
  end

  assign done = vld[D-1];

  // Stages 1-4: t saturation, squares, Bernstein weights.
  bz_weights #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_weights (
    .clk     (clk),
    .param_t (param_t),
    .w0      (w0),
    .w1      (w1),
    .w2      (w2),
    .w3      (w3),
    .uu      (uu),
    .ut      (ut),
    .tt      (tt)
  );

  // Stages 5-7: one lane per axis, sharing the weights.
  bz_axis #(
    .COORD_WIDTH(COORD_WIDTH),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_axis_x (
    .clk   (clk),
    .p0    (start_x),
    .p1    (ctrl1_x),
    .p2    (ctrl2_x),
    .p3    (end_x),
    .w0    (w0),
    .w1    (w1),
    .w2    (w2),
    .w3    (w3),
    .uu    (uu),
    .ut    (ut),
    .tt    (tt),
    .point (point_x),
    .slope (slope_x)
  );

  bz_axis #(
    .COORD_WIDTH(COORD_WIDTH),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_axis_y (
    .clk   (clk),
    .p0    (start_y),
    .p1    (ctrl1_y),
    .p2    (ctrl2_y),
    .p3    (end_y),
    .w0    (w0),
    .w1    (w1),
    .w2    (w2),
    .w3    (w3),
    .uu    (uu),
    .ut    (ut),
    .tt    (tt),
    .point (point_y),
    .slope (slope_y)
  );

endmodule

/* rtl/bz_check.sv */
// Port-level checker for the cubic Bezier evaluator, bound to the top level.
// Depends on bz_pkg and cubic_bezier_point_and_tangent.
module bz_check #(
  parameter int COORD_WIDTH = bz_pkg::COORD_WIDTH
) (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    start,
  input logic                                    busy,
  input logic                                    done,
  input logic signed [COORD_WIDTH+2:0]           slope_x,
  input logic signed [COORD_WIDTH+2:0]           slope_y
);

  localparam int SW = COORD_WIDTH + 3;
  localparam logic signed [SW-1:0] SMAX = (SW'(3) <<< COORD_WIDTH) - SW'(1);
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  // every result traces back to a request exactly one latency earlier
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, bz_pkg::PIPE_DEPTH))
    else $error("result strobe without matching request");

  // no request is dropped
  a_request_completes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##7 done)
    else $error("request produced no result");

  // slope saturation bounds
  a_slope_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (slope_x <= SMAX && slope_x >= SMIN && slope_y <= SMAX && slope_y >= SMIN))
    else $error("slope outside saturation range");

endmodule

bind cubic_bezier_point_and_tangent bz_check #(
  .COORD_WIDTH(COORD_WIDTH)
) u_bz_check (.*);

/* tb/bz_tb_pkg.sv */
// Curve-sample checker for the cubic Bezier evaluator testbench.
// Keeps its own copy of the control points and predicts point and slope per request.
// Depends on bz_pkg.
package bz_tb_pkg;
  import bz_pkg::*;

  localparam int     CW        = COORD_WIDTH;
  localparam int     SW        = COORD_WIDTH + 3;
  localparam longint T_ONE     = longint'(1) << T_FRAC_BITS;
  localparam longint T_HALF    = longint'(1) << (T_FRAC_BITS - 1);
  localparam longint POINT_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint POINT_MIN = -(longint'(1) << (CW - 1));
  localparam longint SLOPE_MAX = 3 * (longint'(1) << CW) - 1;
  localparam longint SLOPE_MIN = -3 * (longint'(1) << CW);

  typedef struct {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
  } curve_sample_t;

  class bezier_checker;
    logic signed [CW-1:0] ctrl_pts [8];
    curve_sample_t        pending_samples [$];
    int                   mismatches;
    int                   samples_checked;

    function new();
      foreach (ctrl_pts[i]) ctrl_pts[i] = '0;
      mismatches      = 0;
      samples_checked = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CW-1:0] v);
      ctrl_pts[idx] = v;
    endfunction

    // floor((v + half) / 2^T): round to nearest, ties up
    function longint round_q(longint v);
      return (v + T_HALF) >>> T_FRAC_BITS;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void eval_axis(longint p0, longint p1, longint p2, longint p3, longint tc,
                            output longint pt, output longint sl);
      longint u, uu, tt, ut, w0, w1, w2, w3, d;
      u  = T_ONE - tc;
      uu = round_q(u * u);
      tt = round_q(tc * tc);
      ut = round_q(u * tc);
      w0 = round_q(uu * u);
      w1 = round_q(3 * uu * tc);
      w2 = round_q(3 * u * tt);
      w3 = round_q(tt * tc);
      pt = clip(round_q(w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3), POINT_MIN, POINT_MAX);
      d  = (p1 - p0) * uu + 2 * (p2 - p1) * ut + (p3 - p2) * tt;
      sl = clip(round_q(3 * d), SLOPE_MIN, SLOPE_MAX);
    endfunction

    function curve_sample_t eval_curve(logic [T_FRAC_BITS:0] t);
      curve_sample_t s;
      longint tc, pt, sl;
      tc = (t > T_ONE) ? T_ONE : longint'(t);
      eval_axis(ctrl_pts[REG_START_X], ctrl_pts[REG_CTRL1_X], ctrl_pts[REG_CTRL2_X],
                ctrl_pts[REG_END_X], tc, pt, sl);
      s.px = pt[CW-1:0];
      s.sx = sl[SW-1:0];
      eval_axis(ctrl_pts[REG_START_Y], ctrl_pts[REG_CTRL1_Y], ctrl_pts[REG_CTRL2_Y],
                ctrl_pts[REG_END_Y], tc, pt, sl);
      s.py = pt[CW-1:0];
      s.sy = sl[SW-1:0];
      return s;
    endfunction

    function void note_request(logic [T_FRAC_BITS:0] t);
      pending_samples.push_back(eval_curve(t));
    endfunction

    task report(string what, logic signed [63:0] got, logic signed [63:0] want);
      mismatches++;
      $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    endtask

    task check_result(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                      logic signed [SW-1:0] sx, logic signed [SW-1:0] sy);
      curve_sample_t ex;
      if (pending_samples.size() == 0) begin
        report("result with no request outstanding, point_x", px, 0);
        return;
      end
      ex = pending_samples.pop_front();
      samples_checked++;
      if (px !== ex.px) report("point_x", px, ex.px);
      if (py !== ex.py) report("point_y", py, ex.py);
      if (sx !== ex.sx) report("slope_x", sx, ex.sx);
      if (sy !== ex.sy) report("slope_y", sy, ex.sy);
    endtask

    // anything still queued at the end never got its result
    task close_out();
      curve_sample_t ex;
      while (pending_samples.size() != 0) begin
        ex = pending_samples.pop_front();
        report("no result for request, expected point_x", 0, ex.px);
      end
    endtask
  endclass

endpackage

/* tb/tb.sv */
// Top-level testbench for the cubic Bezier point and tangent evaluator.
// Drives requests and control point writes, checks every result via bz_tb_pkg.
// Depends on bz_pkg, bz_tb_pkg and the evaluator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bz_pkg::*;
  import bz_tb_pkg::*;

  localparam int RANDOM_REQUESTS = 700;
  localparam int TW = T_FRAC_BITS + 1;
  // t codes: exactly 1.0, and the top of the 17-bit input
  localparam logic [T_FRAC_BITS:0] T_FULL = TW'(1) << T_FRAC_BITS;
  localparam int unsigned T_TOP = (1 << (T_FRAC_BITS + 1)) - 1;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [T_FRAC_BITS:0]     param_t;
  logic                     done;
  logic signed [CW-1:0]     point_x;
  logic signed [CW-1:0]     point_y;
  logic signed [SW-1:0]     slope_x;
  logic signed [SW-1:0]     slope_y;
  logic                     wr_en;
  logic [REG_IDX_WIDTH-1:0] wr_index;
  logic [CW-1:0]            wr_data;

  bezier_checker board = new();

  int requests_sent;
  int random_sent;
  int point_sets;
  int reg_writes;

  cubic_bezier_point_and_tangent dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .param_t(param_t),
    .done(done),
    .point_x(point_x),
    .point_y(point_y),
    .slope_x(slope_x),
    .slope_y(slope_y),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Results are sampled at the edge that ends their strobe cycle; the DUT
  // updates its outputs with nonblocking assignments, so these are the
  // values that were on the ports during that cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      board.check_result(point_x, point_y, slope_x, slope_y);
    end
  end

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Hold the request until an edge sees busy low. The expectation is
  // queued here, in the same process, so a drain check right after can
  // never miss a request accepted at this very edge.
  task automatic send_request(input logic [T_FRAC_BITS:0] t);
    start   <= 1'b1;
    param_t <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(t);
    requests_sent++;
  endtask

  task automatic stop_requests();
    start <= 1'b0;
  endtask

  // Idle cycles with noise on param_t; zero length keeps start high.
  task automatic idle_for(input int n);
    if (n == 0) return;
    start   <= 1'b0;
    param_t <= TW'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_results();
    while (board.pending_samples.size() != 0) @(posedge clk);
  endtask

  // mostly back to back or short gaps, now and then a long one
  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Weighted t: the end points, the saturating range above 1.0, raw
  // 17-bit noise so every input bit toggles, and plenty of in-range values.
  function automatic logic [T_FRAC_BITS:0] random_t();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return T_FULL;
      2: return TW'($urandom_range(T_FULL + 1, T_TOP));
      3: return TW'($urandom);
      default: return TW'($urandom_range(0, T_FULL));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Control point writes (only issued with the pipeline drained)
  // ---------------------------------------------------------------------

  // leaves wr_en high so writes can go back to back; caller lowers it
  task automatic write_reg(input reg_idx_t idx, input logic [CW-1:0] v);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= v;
    @(posedge clk);
    board.set_reg(idx, v);
    reg_writes++;
  endtask

  task automatic set_points(input logic [CW-1:0] vals [8]);
    foreach (vals[i]) write_reg(reg_idx_t'(i), vals[i]);
    wr_en <= 1'b0;
  endtask

  function automatic logic [CW-1:0] random_coord();
    case ($urandom_range(0, 9))
      0: return CW'(POINT_MAX);
      1: return CW'(POINT_MIN);
      2: return '0;
      3: return '1;
      default: return CW'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    logic [CW-1:0]        pts [8];
    logic [T_FRAC_BITS:0] sweep [8];
    int                   phase_len;
    int                   hold_at;
    bit                   gaps_on;

    rst      = 1'b1;
    start    = 1'b0;
    param_t  = '0;
    wr_en    = 1'b0;
    wr_index = REG_START_X;
    wr_data  = '0;
    requests_sent = 0;
    random_sent   = 0;
    point_sets    = 0;
    reg_writes    = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // control points still at reset (all zero): curve collapses to origin
    send_request('0);
    send_request(T_FULL);

    // t sweep: ends, thirds, half, just below 1.0, 1.0, top of input range
    sweep = '{'0, 17'd1, 17'd21845, 17'd32768, 17'd43690, 17'd65535, T_FULL,
              17'h1FFFF};

    // all points at the positive limit: weights summing above one push the
    // point past full scale, so the point saturates
    stop_requests();
    wait_results();
    foreach (pts[i]) pts[i] = CW'(POINT_MAX);
    set_points(pts);
    point_sets++;
    foreach (sweep[i]) send_request(sweep[i]);

    // all points at the negative limit
    stop_requests();
    wait_results();
    foreach (pts[i]) pts[i] = CW'(POINT_MIN);
    set_points(pts);
    point_sets++;
    send_request(sweep[0]);
    send_request(sweep[3]);
    send_request(sweep[5]);
    send_request(sweep[7]);

    // alternating extremes: x goes max,min,max,min and y the other way,
    // giving the largest control point differences for the slope
    stop_requests();
    wait_results();
    foreach (pts[i]) pts[i] = (((i / 2) + i) % 2 == 0) ? CW'(POINT_MAX) : CW'(POINT_MIN);
    set_points(pts);
    point_sets++;
    send_request('0);
    send_request(17'd16384);
    send_request(17'd32768);
    send_request(17'd49152);
    send_request(T_FULL);
    send_request(17'd98304);

    // --- random phases ---
    // Each phase drains, loads a new set of control points (all of them, or
    // sometimes only a random subset), then streams requests with or
    // without gaps. Somewhere in each phase the sender holds off until
    // every outstanding result is back.
    for (int phase = 0; random_sent < RANDOM_REQUESTS; phase++) begin
      stop_requests();
      wait_results();
      if (phase == 0 || $urandom_range(0, 2) != 0) begin
        foreach (pts[i]) pts[i] = random_coord();
        set_points(pts);
      end else begin
        foreach (pts[i]) begin
          if ($urandom_range(0, 1) != 0) write_reg(reg_idx_t'(i), random_coord());
        end
        wr_en <= 1'b0;
      end
      point_sets++;

      gaps_on   = ($urandom_range(0, 2) != 0);
      phase_len = $urandom_range(40, 100);
      hold_at   = $urandom_range(5, phase_len - 5);
      for (int n = 0; n < phase_len; n++) begin
        send_request(random_t());
        random_sent++;
        if (n == hold_at) begin
          stop_requests();
          wait_results();
        end else if (gaps_on) begin
          idle_for(gap_len());
        end
      end
    end

    // --- wrap up ---
    stop_requests();
    wait_results();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    board.close_out();

    $display("Sent %0d requests (%0d random) over %0d control point sets, %0d register writes.",
             requests_sent, random_sent, point_sets, reg_writes);
    $display("Checked %0d point/slope results, %0d field mismatches.",
             board.samples_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("Run timed out.");
    $display("tb NOT OK");
    $finish;
  end

endmodule
